// ===== sv/strip_fan_to_triangle_list_assert.svh =====
// Assertion macros used by the checker file of the strip/fan assembler.
`ifndef STRIP_FAN_TO_TRIANGLE_LIST_ASSERT_SVH
`define STRIP_FAN_TO_TRIANGLE_LIST_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STFL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define STFL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/stfl_pkg.sv =====
// Types and constants shared by the strip/fan to triangle list assembler.
package stfl_pkg;

	localparam int unsigned WORD_W = 32;
	localparam int unsigned OUT_IDX_W = 16;
	localparam logic [OUT_IDX_W-1:0] TOTAL_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		PH_COUNT = 3'b001,
		PH_S     = 3'b010,
		PH_T     = 3'b100
	} phase_t;

	typedef struct packed {
		logic                 vertex_valid;
		logic [OUT_IDX_W-1:0] vertex_index;
		logic [WORD_W-1:0]    s_bits;
		logic [WORD_W-1:0]    t_bits;
		logic                 tri_valid;
		logic [OUT_IDX_W-1:0] corner_a;
		logic [OUT_IDX_W-1:0] corner_b;
		logic [OUT_IDX_W-1:0] corner_c;
		logic                 list_end;
		logic [OUT_IDX_W-1:0] triangle_total;
	} result_t;

endpackage

// ===== sv/strip_fan_to_triangle_list.sv =====
// Path: a command word is registered in the input stage, and its result, if any, in the output register.
// Throughput: one command word per cycle; the input stage stalls only when the
// word in it yields a result and the output register is full and not taken.
// Reset: arst_n clears the run state, the input stage and the output valid;
// the first list starts numbering vertices from zero.
module strip_fan_to_triangle_list import stfl_pkg::*; #(
	parameter int unsigned INDEX_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	input  logic [WORD_W-1:0]    command_word,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic                 vertex_valid,
	output logic [OUT_IDX_W-1:0] vertex_index,
	output logic [WORD_W-1:0]    s_bits,
	output logic [WORD_W-1:0]    t_bits,
	output logic                 tri_valid,
	output logic [OUT_IDX_W-1:0] corner_a,
	output logic [OUT_IDX_W-1:0] corner_b,
	output logic [OUT_IDX_W-1:0] corner_c,
	output logic                 list_end,
	output logic [OUT_IDX_W-1:0] triangle_total
);

	logic              valid_s1;
	logic [WORD_W-1:0] word_s1;
	logic              step;
	logic              has_result;
	logic              out_free;
	result_t           res;
	result_t           res_q;
	logic              res_valid_q;

	stfl_core #(
		.INDEX_BITS(INDEX_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.word      (word_s1),
		.has_result(has_result),
		.res       (res)
	);

	assign out_free  = !res_valid_q || res_ready;
	// words that yield nothing pass even while a result waits
	assign step      = valid_s1 && (!has_result || out_free);
	assign cmd_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid)
			word_s1 <= command_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step && has_result) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && has_result)
			res_q <= res;
	end

	assign res_valid      = res_valid_q;
	assign vertex_valid   = res_q.vertex_valid;
	assign vertex_index   = res_q.vertex_index;
	assign s_bits         = res_q.s_bits;
	assign t_bits         = res_q.t_bits;
	assign tri_valid      = res_q.tri_valid;
	assign corner_a       = res_q.corner_a;
	assign corner_b       = res_q.corner_b;
	assign corner_c       = res_q.corner_c;
	assign list_end       = res_q.list_end;
	assign triangle_total = res_q.triangle_total;

endmodule

// ===== sv/stfl_core.sv =====
// Run state of the assembler and the per-word decode of one command word.
module stfl_core import stfl_pkg::*; #(
	parameter int unsigned INDEX_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [WORD_W-1:0] word,
	output logic              has_result,
	output result_t           res
);

	localparam logic [INDEX_BITS-1:0] IDX_ONE = INDEX_BITS'(1);
	localparam logic [INDEX_BITS-1:0] IDX_TWO = INDEX_BITS'(2);

	phase_t                phase_q, phase_n;
	logic [WORD_W-1:0]     run_length_q, run_length_n;
	logic [WORD_W-1:0]     position_q, position_n;
	logic                  fan_q, fan_n;
	logic [INDEX_BITS-1:0] first_q, first_n;
	logic [INDEX_BITS-1:0] next_q, next_n;
	logic [WORD_W-1:0]     held_s_q, held_s_n;
	logic [OUT_IDX_W-1:0]  tri_count_q, tri_count_n;

	logic [INDEX_BITS-1:0] p0, p1;

	function automatic logic [OUT_IDX_W-1:0] idx16(input logic [INDEX_BITS-1:0] v);
		logic [31:0] wide;
		wide = 32'(v);
		return wide[OUT_IDX_W-1:0];
	endfunction

	assign p1 = next_q - IDX_ONE;
	assign p0 = next_q - IDX_TWO;

	always_comb begin
		res          = '0;
		has_result   = 1'b0;
		phase_n      = phase_q;
		run_length_n = run_length_q;
		position_n   = position_q;
		fan_n        = fan_q;
		first_n      = first_q;
		next_n       = next_q;
		held_s_n     = held_s_q;
		tri_count_n  = tri_count_q;
		unique case (phase_q)
			PH_S: begin
				held_s_n = word;
				phase_n  = PH_T;
			end
			PH_T: begin
				has_result       = 1'b1;
				res.vertex_valid = 1'b1;
				res.vertex_index = idx16(next_q);
				res.s_bits       = held_s_q;
				res.t_bits       = word;
				if (position_q >= WORD_W'(2)) begin
					res.tri_valid = 1'b1;
					// next_q tracks first + position modulo the index width
					if (fan_q) begin
						res.corner_a = idx16(first_q);
						res.corner_b = idx16(p1);
						res.corner_c = idx16(next_q);
					end else if (position_q[0]) begin
						res.corner_a = idx16(next_q);
						res.corner_b = idx16(p1);
						res.corner_c = idx16(p0);
					end else begin
						res.corner_a = idx16(p0);
						res.corner_b = idx16(p1);
						res.corner_c = idx16(next_q);
					end
					if (tri_count_q != TOTAL_MAX)
						tri_count_n = tri_count_q + OUT_IDX_W'(1);
				end
				next_n     = next_q + IDX_ONE;
				position_n = position_q + WORD_W'(1);
				phase_n    = (position_n >= run_length_q) ? PH_COUNT : PH_S;
			end
			default: begin
				if (word == '0) begin
					has_result         = 1'b1;
					res.list_end       = 1'b1;
					res.triangle_total = tri_count_q;
					tri_count_n        = '0;
					next_n             = '0;
					position_n         = '0;
					run_length_n       = '0;
					phase_n            = PH_COUNT;
				end else begin
					fan_n        = word[WORD_W-1];
					run_length_n = word[WORD_W-1] ? (WORD_W'(0) - word) : word;
					position_n   = '0;
					first_n      = next_q;
					phase_n      = PH_S;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_COUNT;
			run_length_q <= '0;
			position_q   <= '0;
			fan_q        <= 1'b0;
			first_q      <= '0;
			next_q       <= '0;
			held_s_q     <= '0;
			tri_count_q  <= '0;
		end else if (step) begin
			phase_q      <= phase_n;
			run_length_q <= run_length_n;
			position_q   <= position_n;
			fan_q        <= fan_n;
			first_q      <= first_n;
			next_q       <= next_n;
			held_s_q     <= held_s_n;
			tri_count_q  <= tri_count_n;
		end
	end

endmodule

// ===== sv/stfl_checker.sv =====
// Port-level checks of the assembler, bound to the top level.
`include "strip_fan_to_triangle_list_assert.svh"

module stfl_checker import stfl_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cmd_valid,
	input logic                 cmd_ready,
	input logic [WORD_W-1:0]    command_word,
	input logic                 res_valid,
	input logic                 res_ready,
	input logic                 vertex_valid,
	input logic [OUT_IDX_W-1:0] vertex_index,
	input logic [WORD_W-1:0]    s_bits,
	input logic [WORD_W-1:0]    t_bits,
	input logic                 tri_valid,
	input logic [OUT_IDX_W-1:0] corner_a,
	input logic [OUT_IDX_W-1:0] corner_b,
	input logic [OUT_IDX_W-1:0] corner_c,
	input logic                 list_end,
	input logic [OUT_IDX_W-1:0] triangle_total
);

	result_t res_bits;
	logic    res_stall;
	logic    cmd_stall;

	assign res_bits = {vertex_valid, vertex_index, s_bits, t_bits, tri_valid, corner_a,
		corner_b, corner_c, list_end, triangle_total};
	assign res_stall = res_valid && !res_ready;
	assign cmd_stall = cmd_valid && !cmd_ready;

	// hold a stalled transaction on either side
	`STFL_ASSERT_NXT(a_cmd_hold, clk, arst_n, cmd_stall,
		cmd_valid && $stable(command_word), "stalled command changed")

	`STFL_ASSERT_NXT(a_res_hold, clk, arst_n, res_stall,
		res_valid && $stable(res_bits), "stalled result changed")

	`STFL_ASSERT_IMP(a_tri_has_vertex, clk, arst_n, res_valid && tri_valid, vertex_valid,
		"triangle without vertex")

	`STFL_ASSERT_IMP(a_end_alone, clk, arst_n, res_valid, vertex_valid != list_end,
		"result is neither vertex nor list end")

	// the last two corners are always adjacent vertices
	`STFL_ASSERT_IMP(a_corner_distinct, clk, arst_n, res_valid && tri_valid,
		corner_b != corner_c, "degenerate triangle edge")

endmodule

bind strip_fan_to_triangle_list stfl_checker u_stfl_checker (.*);

// ===== dv/tb_top.sv =====
// Testbench for the strip/fan to triangle list assembler: random command lists, scoreboard check.
module tb_top;
	import stfl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [WORD_W-1:0] word;
		bit                quiet;
	} cmd_item_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cmd_valid = 1'b0;
	logic                 cmd_ready;
	logic [WORD_W-1:0]    command_word = '0;
	logic                 res_valid;
	logic                 res_ready = 1'b0;
	logic                 vertex_valid;
	logic [OUT_IDX_W-1:0] vertex_index;
	logic [WORD_W-1:0]    s_bits;
	logic [WORD_W-1:0]    t_bits;
	logic                 tri_valid;
	logic [OUT_IDX_W-1:0] corner_a;
	logic [OUT_IDX_W-1:0] corner_b;
	logic [OUT_IDX_W-1:0] corner_c;
	logic                 list_end;
	logic [OUT_IDX_W-1:0] triangle_total;

	strip_fan_to_triangle_list dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Assembler state as seen by the predictor
	phase_t               asm_phase = PH_COUNT;
	logic [31:0]          run_len = '0;
	logic [31:0]          run_pos = '0;
	logic                 fan_run = 1'b0;
	logic [OUT_IDX_W-1:0] first_vtx = '0;
	logic [OUT_IDX_W-1:0] next_vtx = '0;
	logic [WORD_W-1:0]    held_s_word = '0;
	logic [OUT_IDX_W-1:0] tri_tally = '0;

	cmd_item_t cmd_words[$];
	result_t   due_results[$];

	int  words_taken = 0;
	int  directed_n = 0;
	int  send_gap = 0;
	int  rx_stall = 0;
	bit  fast_phase = 1'b0;
	bit  hold_off = 1'b0;
	int  errors = 0;
	int  mismatches = 0;
	int  seen_lists = 0;
	int  seen_vertices = 0;
	int  seen_triangles = 0;

	// Advance the assembler by one command word; return 1 when it yields a result.
	function automatic bit assemble_word(input logic [WORD_W-1:0] w, output result_t r);
		logic [OUT_IDX_W-1:0] p0;
		logic [OUT_IDX_W-1:0] p1;
		logic [OUT_IDX_W-1:0] p2;
		logic [31:0]          i;
		bit                   got;
		r = '0;
		got = 1'b0;
		case (asm_phase)
		PH_S: begin
			held_s_word = w;
			asm_phase = PH_T;
		end
		PH_T: begin
			i = run_pos;
			got = 1'b1;
			r.vertex_valid = 1'b1;
			r.vertex_index = next_vtx;
			r.s_bits = held_s_word;
			r.t_bits = w;
			if (i >= 32'd2) begin
				p2 = first_vtx + i[OUT_IDX_W-1:0];
				p1 = p2 - 16'd1;
				p0 = p2 - 16'd2;
				r.tri_valid = 1'b1;
				if (fan_run) begin
					{r.corner_a, r.corner_b, r.corner_c} = {first_vtx, p1, p2};
				end else if (i[0]) begin
					{r.corner_a, r.corner_b, r.corner_c} = {p2, p1, p0};
				end else begin
					{r.corner_a, r.corner_b, r.corner_c} = {p0, p1, p2};
				end
				if (tri_tally != TOTAL_MAX) tri_tally = tri_tally + 16'd1;
			end
			next_vtx = next_vtx + 16'd1;
			run_pos = i + 32'd1;
			asm_phase = (run_pos >= run_len) ? PH_COUNT : PH_S;
		end
		default: begin
			if (w == '0) begin
				got = 1'b1;
				r.list_end = 1'b1;
				r.triangle_total = tri_tally;
				tri_tally = '0;
				next_vtx = '0;
				run_pos = '0;
				run_len = '0;
				asm_phase = PH_COUNT;
			end else begin
				fan_run = w[31];
				run_len = w[31] ? (32'd0 - w) : w;
				run_pos = '0;
				first_vtx = next_vtx;
				asm_phase = PH_S;
			end
		end
		endcase
		return got;
	endfunction

	// Mostly short gaps, now and then a long one; none in the quiet stretch.
	function automatic int pick_gap(input bit quiet);
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic logic [WORD_W-1:0] rand_bits();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return $urandom;
	endfunction

	task automatic push_word(input logic [WORD_W-1:0] w, input bit quiet);
		cmd_item_t it;
		it.word = w;
		it.quiet = quiet;
		cmd_words.push_back(it);
	endtask

	// Signed count: negative opens a fan, positive a strip.
	task automatic push_run(input int count, input int verts, input bit quiet);
		push_word(count, quiet);
		repeat (verts) begin
			push_word(rand_bits(), quiet);
			push_word(rand_bits(), quiet);
		end
	endtask

	task automatic push_random_list();
		int n_runs;
		int len;
		int r;
		n_runs = $urandom_range(0, 4);
		repeat (n_runs) begin
			r = $urandom_range(0, 99);
			if (r < 10) len = $urandom_range(1, 2);
			else if (r < 90) len = $urandom_range(3, 8);
			else len = $urandom_range(9, 40);
			push_run($urandom_range(0, 1) ? -len : len, len, 1'b0);
		end
		push_word('0, 1'b0);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			errors++;
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	// Driver: take the transaction, update the prediction, then offer the next word.
	always @(posedge clk) begin
		cmd_item_t it;
		result_t   exp_r;
		if (arst_n) begin
			if (cmd_valid && cmd_ready) begin
				words_taken++;
				if (assemble_word(command_word, exp_r)) due_results.push_back(exp_r);
			end
			if (!cmd_valid || cmd_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (cmd_words.size() > 0) begin
					it = cmd_words.pop_front();
					cmd_valid <= 1'b1;
					command_word <= it.word;
					fast_phase <= it.quiet;
					send_gap = pick_gap(it.quiet);
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each result transaction against the oldest expectation.
	always @(posedge clk) begin
		result_t e;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (due_results.size() == 0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10) $display("%0t: result with none expected", $realtime);
				end else begin
					e = due_results.pop_front();
					check_field("vertex_valid", 32'(e.vertex_valid), 32'(vertex_valid));
					check_field("vertex_index", 32'(e.vertex_index), 32'(vertex_index));
					check_field("s_bits", e.s_bits, s_bits);
					check_field("t_bits", e.t_bits, t_bits);
					check_field("tri_valid", 32'(e.tri_valid), 32'(tri_valid));
					check_field("corner_a", 32'(e.corner_a), 32'(corner_a));
					check_field("corner_b", 32'(e.corner_b), 32'(corner_b));
					check_field("corner_c", 32'(e.corner_c), 32'(corner_c));
					check_field("list_end", 32'(e.list_end), 32'(list_end));
					check_field("triangle_total", 32'(e.triangle_total),
						32'(triangle_total));
					if (e.list_end) seen_lists++;
					if (e.vertex_valid) seen_vertices++;
					if (e.tri_valid) seen_triangles++;
				end
			end
			if (rx_stall > 0) begin
				rx_stall--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= !hold_off;
				if (!fast_phase && $urandom_range(0, 7) == 0) rx_stall = pick_gap(1'b0);
			end
		end
	end

	// Hold the result side off while words keep coming, so the input stalls.
	initial begin
		wait (directed_n > 0 && words_taken >= directed_n + 150);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("Timeout with %0d results still due", due_results.size());
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		// Directed: extreme coordinates, both windings, short runs, empty list
		push_word(32'd4, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'h8000_0000, 1'b0);
		push_word(32'h7FFF_FFFF, 1'b0);
		push_word(32'hFFFF_FFFF, 1'b0);
		push_word(32'h0000_0000, 1'b0);
		push_word(32'h5555_5555, 1'b0);
		push_word(32'hAAAA_AAAA, 1'b0);
		push_run(-3, 3, 1'b0);
		push_run(-1, 1, 1'b0);
		push_run(2, 2, 1'b0);
		push_word('0, 1'b0);
		push_word('0, 1'b0);
		directed_n = cmd_words.size();

		while (cmd_words.size() < directed_n + 800) push_random_list();

		// Most negative count: a fan that never finishes, so it goes last
		push_run(32'h8000_0000, 4, 1'b0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (cmd_words.size() == 0 && !cmd_valid);
		wait (due_results.size() == 0);
		repeat (16) @(posedge clk);

		if (due_results.size() != 0) begin
			errors++;
			$display("%0d expected results never arrived", due_results.size());
		end
		$display("Ran %0d command words: %0d list ends, %0d vertices, %0d triangles checked.",
			words_taken, seen_lists, seen_vertices, seen_triangles);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d errors", errors);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== strip_fan_to_triangle_list.f =====
+incdir+sv
sv/stfl_pkg.sv
sv/stfl_core.sv
sv/strip_fan_to_triangle_list.sv
sv/stfl_checker.sv
dv/tb_top.sv
